[rtl/clhm_pkg.sv]
// CAN link health monitor: shared types and constants.
// Event and result transaction structs, code enums, register reset values.
// No dependencies.
`timescale 1ns / 1ps

package clhm_pkg;

  typedef enum logic [1:0] {
    ACT_TX_DONE      = 2'd0,
    ACT_BUS_ERROR    = 2'd1,
    ACT_STATE_CHANGE = 2'd2,
    ACT_CHECK        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CTRL_ACTIVE  = 2'd0,
    CTRL_WARNING = 2'd1,
    CTRL_PASSIVE = 2'd2,
    CTRL_BUSOFF  = 2'd3
  } ctrl_state_t;

  typedef enum logic [1:0] {
    LINK_DOWN   = 2'd0,
    LINK_UP     = 2'd1,
    LINK_BUSOFF = 2'd2
  } link_t;

  typedef enum logic [1:0] {
    CHG_NONE         = 2'd0,
    CHG_CONNECTED    = 2'd1,
    CHG_DISCONNECTED = 2'd2
  } change_t;

  typedef enum logic {
    REG_PINGS_TO_CONNECT = 1'b0,
    REG_ERROR_LIMIT      = 1'b1
  } reg_index_t;

  localparam int unsigned PING_W = 4;
  localparam int unsigned ERR_W  = 8;
  localparam int unsigned CFG_W  = 8;

  localparam logic [PING_W-1:0] PINGS_RESET = 4'd3;
  localparam logic [ERR_W-1:0]  LIMIT_RESET = 8'd3;
  localparam logic [PING_W-1:0] PING_MAX    = 4'hF;
  localparam logic [ERR_W-1:0]  ERR_MAX     = 8'hFF;

  typedef struct packed {
    action_t     action;
    logic        tx_success;
    logic        stuff_error;
    logic        ack_error;
    ctrl_state_t new_controller_state;
  } in_item_t;

  typedef struct packed {
    link_t   link_state;
    change_t connection_change;
    logic    send_ping;
    logic    request_recovery;
    logic    wake_check;
  } out_item_t;

endpackage

[rtl/can_link_health_monitor_core.sv]
// CAN link health monitor, top level.
// Config registers, input stage, engine and result register.
// Uses clhm_pkg, clhm_in_stage, clhm_engine.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  event   | in_valid, in_ready, in_data          | in
//  result  | out_valid, out_ready, out_data       | out
//  config  | cfg_we, cfg_index, cfg_wdata         | in
//
// One result per event; an event enters every cycle when the result side
// keeps up. An event passes the input register, then the result register.
// State update and result come from one pass of short logic in the engine.
// Reset (synchronous) empties both stages, restores register defaults.
// A stalled result holds the input stage, which then drops in_ready.
`timescale 1ns / 1ps

module can_link_health_monitor_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  clhm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output clhm_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  clhm_pkg::reg_index_t        cfg_index,
  input  logic [clhm_pkg::CFG_W-1:0]  cfg_wdata
);
  import clhm_pkg::*;

  logic              hold_valid;
  in_item_t          hold_data;
  logic              advance;
  out_item_t         res;
  logic [PING_W-1:0] pings_to_connect;
  logic [ERR_W-1:0]  error_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pings_to_connect <= PINGS_RESET;
      error_limit      <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PINGS_TO_CONNECT: pings_to_connect <= cfg_wdata[PING_W-1:0];
        REG_ERROR_LIMIT:      error_limit      <= cfg_wdata[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance = hold_valid && (!out_valid || out_ready);

  clhm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  clhm_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .ev               (hold_data),
    .pings_to_connect (pings_to_connect),
    .error_limit      (error_limit),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

[rtl/clhm_in_stage.sv]
// Input register stage of the CAN link health monitor.
// Holds one event transaction until the engine consumes it. Uses clhm_pkg.
`timescale 1ns / 1ps

module clhm_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  clhm_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              hold_valid,
  output clhm_pkg::in_item_t hold_data
);
  import clhm_pkg::*;

  // stage frees up in the same cycle its content moves on; closed during reset
  assign in_ready = !rst && (!hold_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

endmodule

[rtl/clhm_engine.sv]
// Link state and error/ping counters of the CAN link health monitor.
// State updates once per consumed event; the result is combinational.
// Uses clhm_pkg.
`timescale 1ns / 1ps

module clhm_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  clhm_pkg::in_item_t                ev,
  input  logic [clhm_pkg::PING_W-1:0]       pings_to_connect,
  input  logic [clhm_pkg::ERR_W-1:0]        error_limit,
  output clhm_pkg::out_item_t               res
);
  import clhm_pkg::*;

  link_t             link_now, link_now_next;
  link_t             link_before, link_before_next;
  logic [ERR_W-1:0]  stuff_error_run, stuff_error_run_next;
  logic [ERR_W-1:0]  ack_error_run, ack_error_run_next;
  logic [PING_W-1:0] good_ping_run, good_ping_run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_now        <= LINK_DOWN;
      link_before     <= LINK_DOWN;
      stuff_error_run <= '0;
      ack_error_run   <= '0;
      good_ping_run   <= '0;
    end else if (fire) begin
      link_now        <= link_now_next;
      link_before     <= link_before_next;
      stuff_error_run <= stuff_error_run_next;
      ack_error_run   <= ack_error_run_next;
      good_ping_run   <= good_ping_run_next;
    end
  end

  always_comb begin
    logic [PING_W-1:0] ping_inc;
    link_now_next        = link_now;
    link_before_next     = link_before;
    stuff_error_run_next = stuff_error_run;
    ack_error_run_next   = ack_error_run;
    good_ping_run_next   = good_ping_run;
    ping_inc             = (good_ping_run != PING_MAX) ? good_ping_run + 1'b1 : PING_MAX;
    res                  = '0;
    res.connection_change = CHG_NONE;

    unique case (ev.action)
      ACT_TX_DONE: begin
        if (ev.tx_success) begin
          stuff_error_run_next = '0;
          ack_error_run_next   = '0;
          res.wake_check       = (link_now != LINK_UP);
        end
      end
      ACT_BUS_ERROR: begin
        if (ev.stuff_error && stuff_error_run != ERR_MAX) begin
          stuff_error_run_next = stuff_error_run + 1'b1;
        end
        if (ev.ack_error && ack_error_run != ERR_MAX) begin
          ack_error_run_next = ack_error_run + 1'b1;
        end
        res.wake_check = (ev.stuff_error || ev.ack_error) && (link_now == LINK_UP);
      end
      ACT_STATE_CHANGE: begin
        unique case (ev.new_controller_state)
          CTRL_ACTIVE: begin
            link_now_next  = LINK_DOWN;
            res.wake_check = 1'b1;
          end
          CTRL_BUSOFF: begin
            link_now_next  = LINK_BUSOFF;
            res.wake_check = 1'b1;
          end
          default: ;
        endcase
      end
      ACT_CHECK: begin
        unique case (link_now)
          LINK_DOWN: begin
            if (ack_error_run == '0 && stuff_error_run == '0) begin
              good_ping_run_next = ping_inc;
              if (ping_inc >= pings_to_connect) begin
                link_now_next         = LINK_UP;
                res.connection_change = CHG_CONNECTED;
                good_ping_run_next    = '0;
              end
            end else begin
              good_ping_run_next = '0;
            end
          end
          LINK_UP: begin
            if (ack_error_run > error_limit || stuff_error_run > error_limit) begin
              link_now_next         = LINK_DOWN;
              res.connection_change = CHG_DISCONNECTED;
            end
          end
          default: begin
            // bus off: report the drop once if the last check saw the link up
            if (link_before == LINK_UP) begin
              res.connection_change = CHG_DISCONNECTED;
            end
            res.request_recovery = 1'b1;
          end
        endcase
        res.send_ping    = (link_now_next == LINK_DOWN);
        link_before_next = link_now_next;
      end
      default: ;
    endcase
    res.link_state = link_now_next;
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable({link_now, link_before, stuff_error_run, ack_error_run, good_ping_run}))
    else $error("engine state changed without an event");

  a_tx_clears: assert property (@(posedge clk) disable iff (rst)
    fire && ev.action == ACT_TX_DONE && ev.tx_success
    |=> stuff_error_run == '0 && ack_error_run == '0)
    else $error("successful transmit did not clear error runs");

  a_check_tracks: assert property (@(posedge clk) disable iff (rst)
    fire && ev.action == ACT_CHECK |=> link_before == link_now)
    else $error("previous link state not captured on check");

  a_connect_clears_pings: assert property (@(posedge clk) disable iff (rst)
    fire && res.connection_change == CHG_CONNECTED
    |=> link_now == LINK_UP && good_ping_run == '0)
    else $error("connect without clearing ping run");

endmodule

[sim/testbench.sv]
// Testbench for can_link_health_monitor_core: random and directed CAN events,
// with a transaction-level shadow of the link state that checks each result.
// Depends on rtl/clhm_pkg.sv and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import clhm_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;

  // Shadow of the monitor state; predicts one status per event.
  class link_monitor_shadow;
    logic [PING_W-1:0] ping_goal;
    logic [ERR_W-1:0]  err_limit;
    link_t             link_now;
    link_t             link_prev;
    logic [ERR_W-1:0]  stuff_run;
    logic [ERR_W-1:0]  ack_run;
    logic [PING_W-1:0] ping_run;
    out_item_t         status_q[$];
    int                errors;

    function new();
      ping_goal = PINGS_RESET;
      err_limit = LIMIT_RESET;
      link_now  = LINK_DOWN;
      link_prev = LINK_DOWN;
      stuff_run = '0;
      ack_run   = '0;
      ping_run  = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PINGS_TO_CONNECT: ping_goal = val[PING_W-1:0];
        REG_ERROR_LIMIT:      err_limit = val[ERR_W-1:0];
      endcase
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void track_event(in_item_t ev);
      out_item_t st;
      st = '0;
      case (ev.action)
        ACT_TX_DONE: begin
          if (ev.tx_success) begin
            stuff_run = '0;
            ack_run   = '0;
            if (link_now != LINK_UP) st.wake_check = 1'b1;
          end
        end
        ACT_BUS_ERROR: begin
          if (ev.stuff_error && stuff_run != ERR_MAX) stuff_run++;
          if (ev.ack_error && ack_run != ERR_MAX) ack_run++;
          if ((ev.stuff_error || ev.ack_error) && link_now == LINK_UP) st.wake_check = 1'b1;
        end
        ACT_STATE_CHANGE: begin
          if (ev.new_controller_state == CTRL_ACTIVE) begin
            link_now      = LINK_DOWN;
            st.wake_check = 1'b1;
          end else if (ev.new_controller_state == CTRL_BUSOFF) begin
            link_now      = LINK_BUSOFF;
            st.wake_check = 1'b1;
          end
        end
        ACT_CHECK: begin
          case (link_now)
            LINK_DOWN: begin
              if (stuff_run == 0 && ack_run == 0) begin
                if (ping_run != PING_MAX) ping_run++;
                if (ping_run >= ping_goal) begin
                  link_now             = LINK_UP;
                  st.connection_change = CHG_CONNECTED;
                  ping_run             = '0;
                end
              end else begin
                ping_run = '0;
              end
            end
            LINK_UP: begin
              if (ack_run > err_limit || stuff_run > err_limit) begin
                link_now             = LINK_DOWN;
                st.connection_change = CHG_DISCONNECTED;
              end
            end
            default: begin
              // bus off: disconnection is reported only if the last check saw it up
              if (link_prev == LINK_UP) st.connection_change = CHG_DISCONNECTED;
              st.request_recovery = 1'b1;
            end
          endcase
          st.send_ping = (link_now == LINK_DOWN);
          link_prev    = link_now;
        end
      endcase
      st.link_state = link_now;
      status_q.push_back(st);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_q.size() == 0) begin
        report("result transaction with no predicted status");
        return;
      end
      want = status_q.pop_front();
      if (got.link_state != want.link_state)
        report($sformatf("link_state %0d, predicted %0d", got.link_state, want.link_state));
      if (got.connection_change != want.connection_change)
        report($sformatf("connection_change %0d, predicted %0d",
                         got.connection_change, want.connection_change));
      if (got.send_ping != want.send_ping)
        report($sformatf("send_ping %0b, predicted %0b", got.send_ping, want.send_ping));
      if (got.request_recovery != want.request_recovery)
        report($sformatf("request_recovery %0b, predicted %0b",
                         got.request_recovery, want.request_recovery));
      if (got.wake_check != want.wake_check)
        report($sformatf("wake_check %0b, predicted %0b", got.wake_check, want.wake_check));
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  reg_index_t         cfg_index = REG_PINGS_TO_CONNECT;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  link_monitor_shadow shadow = new();

  bit idle_on      = 1'b1;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int events_sent  = 0;
  int cur_goal     = PINGS_RESET;
  int cur_limit    = LIMIT_RESET;

  int goal_plan[PHASES]  = '{1, 0, 15, 2, 4, 7, 0, 3};
  int limit_plan[PHASES] = '{0, 255, 254, 1, 6, 200, 0, 3};
  bit idle_plan[PHASES]  = '{1, 1, 1, 0, 1, 1, 1, 0};

  can_link_health_monitor_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result-side backpressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Transaction monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) shadow.track_event(in_data);
      if (out_valid && out_ready) shadow.check_status(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic in_item_t rand_ev(action_t act);
    in_item_t ev;
    ev.action               = act;
    ev.tx_success           = 1'($urandom_range(0, 1));
    ev.stuff_error          = 1'($urandom_range(0, 1));
    ev.ack_error            = 1'($urandom_range(0, 1));
    ev.new_controller_state = ctrl_state_t'($urandom_range(0, 3));
    return ev;
  endfunction

  function automatic in_item_t mk(action_t act, logic tx, logic st, logic ak, ctrl_state_t cs);
    in_item_t ev;
    ev.action               = act;
    ev.tx_success           = tx;
    ev.stuff_error          = st;
    ev.ack_error            = ak;
    ev.new_controller_state = cs;
    return ev;
  endfunction

  task automatic send_event(input in_item_t ev);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  task automatic stop_events();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input int n);
    int       start;
    int       pick;
    int       k;
    bit       long_burst;
    bit       use_ack;
    in_item_t ev;
    start = events_sent;
    while (events_sent - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        // clean the error counts, ping up to connected, then load with errors
        ev = rand_ev(ACT_TX_DONE);
        ev.tx_success = 1'b1;
        send_event(ev);
        repeat ((cur_goal == 0) ? 1 : cur_goal) send_event(rand_ev(ACT_CHECK));
        long_burst = ($urandom_range(0, 39) == 0);
        use_ack    = 1'($urandom_range(0, 1));
        if (long_burst) k = cur_limit + 2;
        else k = $urandom_range(0, (cur_limit < 6) ? cur_limit + 2 : 8);
        repeat (k) begin
          ev = rand_ev(ACT_BUS_ERROR);
          if (long_burst) begin
            if (use_ack) ev.ack_error = 1'b1;
            else ev.stuff_error = 1'b1;
          end else if (!ev.stuff_error && !ev.ack_error) begin
            ev.ack_error = 1'b1;
          end
          send_event(ev);
        end
        send_event(rand_ev(ACT_CHECK));
      end else if (pick < 7) begin
        // bus off, recovery checks, back to error active
        ev = rand_ev(ACT_STATE_CHANGE);
        ev.new_controller_state = CTRL_BUSOFF;
        send_event(ev);
        repeat ($urandom_range(1, 2)) send_event(rand_ev(ACT_CHECK));
        if ($urandom_range(0, 1)) send_event(rand_ev(ACT_TX_DONE));
        ev = rand_ev(ACT_STATE_CHANGE);
        ev.new_controller_state = CTRL_ACTIVE;
        send_event(ev);
      end else begin
        repeat ($urandom_range(1, 6)) send_event(rand_ev(action_t'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass at the reset register values (3 pings, limit 3).
    send_event(mk(ACT_CHECK,        1'b1, 1'b0, 1'b0, CTRL_BUSOFF));
    send_event(mk(ACT_TX_DONE,      1'b0, 1'b1, 1'b1, CTRL_ACTIVE));   // failed transmit
    send_event(mk(ACT_CHECK,        1'b0, 1'b1, 1'b1, CTRL_ACTIVE));
    send_event(mk(ACT_CHECK,        1'b1, 1'b1, 1'b1, CTRL_BUSOFF));   // connects
    send_event(mk(ACT_BUS_ERROR,    1'b0, 1'b1, 1'b0, CTRL_BUSOFF));
    send_event(mk(ACT_BUS_ERROR,    1'b1, 1'b0, 1'b1, CTRL_ACTIVE));
    send_event(mk(ACT_BUS_ERROR,    1'b0, 1'b0, 1'b0, CTRL_BUSOFF));   // no flags
    send_event(mk(ACT_BUS_ERROR,    1'b0, 1'b1, 1'b1, CTRL_WARNING));
    send_event(mk(ACT_BUS_ERROR,    1'b0, 1'b1, 1'b1, CTRL_PASSIVE));
    send_event(mk(ACT_CHECK,        1'b0, 1'b0, 1'b0, CTRL_ACTIVE));   // at limit, stays up
    send_event(mk(ACT_BUS_ERROR,    1'b1, 1'b1, 1'b0, CTRL_ACTIVE));
    send_event(mk(ACT_CHECK,        1'b1, 1'b1, 1'b1, CTRL_WARNING));  // drops
    send_event(mk(ACT_CHECK,        1'b0, 1'b0, 1'b0, CTRL_PASSIVE));  // errors clear pings
    send_event(mk(ACT_TX_DONE,      1'b1, 1'b1, 1'b1, CTRL_BUSOFF));
    send_event(mk(ACT_STATE_CHANGE, 1'b1, 1'b1, 1'b1, CTRL_WARNING));
    send_event(mk(ACT_STATE_CHANGE, 1'b0, 1'b0, 1'b0, CTRL_PASSIVE));
    send_event(mk(ACT_STATE_CHANGE, 1'b0, 1'b1, 1'b0, CTRL_BUSOFF));
    send_event(mk(ACT_CHECK,        1'b1, 1'b0, 1'b1, CTRL_ACTIVE));   // recovery, was down
    send_event(mk(ACT_STATE_CHANGE, 1'b1, 1'b0, 1'b1, CTRL_ACTIVE));
    send_event(mk(ACT_CHECK,        1'b0, 1'b0, 1'b0, CTRL_ACTIVE));
    send_event(mk(ACT_CHECK,        1'b0, 1'b0, 1'b0, CTRL_ACTIVE));
    send_event(mk(ACT_CHECK,        1'b0, 1'b0, 1'b0, CTRL_ACTIVE));
    send_event(mk(ACT_STATE_CHANGE, 1'b0, 1'b0, 1'b0, CTRL_BUSOFF));
    send_event(mk(ACT_CHECK,        1'b0, 1'b0, 1'b0, CTRL_WARNING));  // recovery, was up
    send_event(mk(ACT_TX_DONE,      1'b1, 1'b0, 1'b0, CTRL_PASSIVE));
    stop_events();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      cur_goal  = goal_plan[p];
      cur_limit = limit_plan[p];
      if (p == 6) begin
        cur_goal  = $urandom_range(0, 15);
        cur_limit = $urandom_range(0, 255);
      end
      write_reg(REG_PINGS_TO_CONNECT, CFG_W'(cur_goal));
      write_reg(REG_ERROR_LIMIT, CFG_W'(cur_limit));
      idle_on = idle_plan[p];
      run_traffic(PHASE_ITEMS);
      stop_events();
      drain();
    end

    if (shadow.pending() != 0) shadow.report("predicted status never arrived");
    if (shadow.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
